// ===== hw/rtl/swbvh_pkg.sv =====
// Shared types and constants of the sliding-window bit-vote hash block.
package swbvh_pkg;

  // Number of attribute lanes, one key byte each.
  localparam int LANES = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int WIN_LEN_W   = 7;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET   = 7'd8;
  localparam logic [LANES-1:0]     LANE_MASK_RESET = 4'hF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LEN   = 2'd0,
    REG_PATTERN_HASH = 2'd1,
    REG_LANE_MASK    = 2'd2
  } cfg_reg_e;

  typedef logic [LANES-1:0][7:0] lane_bytes_t;

  // One input request.
  typedef struct packed {
    logic [7:0] value_0;
    logic [7:0] value_1;
    logic [7:0] value_2;
    logic [7:0] value_3;
    logic       item_missing;
    logic       restart;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [7:0] hash_0;
    logic [7:0] hash_1;
    logic [7:0] hash_2;
    logic [7:0] hash_3;
    logic       window_full;
    logic       match;
  } out_item_t;

  // Compare settings handed from the front end to the back end.
  typedef struct packed {
    lane_bytes_t      pattern;
    logic [LANES-1:0] mask;
  } cfg_t;

  // Classified item travelling from the front end to the back end.
  typedef struct packed {
    logic        clear;
    logic        missing;
    logic        sub;
    logic        full;
    lane_bytes_t new_bytes;
    lane_bytes_t old_bytes;
  } cmd_t;

endpackage

// ===== hw/rtl/swbvh_if.sv =====
// Channel interfaces of the sliding-window bit-vote hash block.
interface swbvh_in_if;
  import swbvh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swbvh_out_if;
  import swbvh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swbvh_cfg_if;
  import swbvh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/swbvh_front.sv =====
// Front end: configuration registers, window bookkeeping and the window store.
module swbvh_front
  import swbvh_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swbvh_in_if.sink    in_i,
  swbvh_cfg_if.sink   cfg_i,
  output cfg_t        cfg_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = CW + 1;

  logic [WIN_LEN_W-1:0] win_len_q;
  logic [CFG_DATA_W-1:0] pattern_q;
  logic [LANES-1:0]     mask_q;
  logic                 pend_clr_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic                 stg_valid_q;
  cmd_t                 stg_q, stg_d;
  lane_bytes_t          rd_q;
  lane_bytes_t          mem_q [MAX_WINDOW];

  logic [CW-1:0] len_eff;
  logic          accept;
  logic          clr;
  logic [CW-1:0] fill_base;
  logic [SW-1:0] slot_base;
  logic [SW-1:0] old_addr;
  logic          sub;

  // Effective window length: zero acts as one, long values saturate.
  always_comb begin
    if (win_len_q == '0) begin
      len_eff = CW'(1);
    end else if (AW'(win_len_q) > AW'(MAX_WINDOW)) begin
      len_eff = CW'(MAX_WINDOW);
    end else begin
      len_eff = CW'(win_len_q);
    end
  end

  // The staging register frees up whenever its entry moves into the queue.
  assign in_i.ready  = !stg_valid_q || cmd_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Classify the request: clearing, leaving entry, next slot and fill.
  always_comb begin
    clr       = in_i.data.restart || in_i.data.item_missing || pend_clr_q;
    fill_base = clr ? '0 : fill_q;
    slot_base = clr ? '0 : slot_q;
    sub       = !in_i.data.item_missing && (fill_base >= len_eff);

    if (AW'(slot_base) >= AW'(len_eff)) begin
      old_addr = SW'(AW'(slot_base) - AW'(len_eff));
    end else begin
      old_addr = SW'(AW'(slot_base) + AW'(MAX_WINDOW) - AW'(len_eff));
    end

    if (in_i.data.item_missing) begin
      fill_d = '0;
      slot_d = '0;
    end else begin
      fill_d = (fill_base < len_eff) ? fill_base + CW'(1) : fill_base;
      slot_d = (AW'(slot_base) == AW'(MAX_WINDOW - 1)) ? '0 : slot_base + SW'(1);
    end

    stg_d.clear     = clr;
    stg_d.missing   = in_i.data.item_missing;
    stg_d.sub       = sub;
    stg_d.full      = (fill_d == len_eff);
    stg_d.new_bytes = {in_i.data.value_3, in_i.data.value_2,
                       in_i.data.value_1, in_i.data.value_0};
    stg_d.old_bytes = '0;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WIN_LEN_RESET;
      pattern_q   <= '0;
      mask_q      <= LANE_MASK_RESET;
      pend_clr_q  <= 1'b0;
      fill_q      <= '0;
      slot_q      <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      // Writing the window length restarts the window.
      if (cfg_i.valid && (cfg_i.index == REG_WINDOW_LEN)) begin
        fill_q     <= '0;
        slot_q     <= '0;
        pend_clr_q <= 1'b1;
      end else if (accept) begin
        fill_q     <= fill_d;
        slot_q     <= slot_d;
        pend_clr_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_WINDOW_LEN:   win_len_q <= cfg_i.data[WIN_LEN_W-1:0];
          REG_PATTERN_HASH: pattern_q <= cfg_i.data;
          REG_LANE_MASK:    mask_q    <= cfg_i.data[LANES-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        stg_valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  // Staged command payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
  end

  // Window store: the leaving entry is read before the slot is overwritten.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[old_addr];
      if (!in_i.data.item_missing) begin
        mem_q[slot_base] <= stg_d.new_bytes;
      end
    end
  end

  // Command toward the queue, with the leaving bytes attached.
  always_comb begin
    cmd_o           = stg_q;
    cmd_o.old_bytes = rd_q;
  end
  assign cmd_valid_o   = stg_valid_q;
  assign cfg_o.pattern = pattern_q;
  assign cfg_o.mask    = mask_q;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_eff)
    else $error("fill count exceeds window length");
  a_slot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    AW'(slot_q) < AW'(MAX_WINDOW))
    else $error("write slot out of range");
`endif

endmodule

// ===== hw/rtl/swbvh_queue.sv =====
// Two-entry command queue between the front end and the back end.
module swbvh_queue
  import swbvh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  localparam int DEPTH = 2;

  cmd_t       entry_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_ptr_q];

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(DEPTH))
    else $error("queue occupancy out of range");
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue occupancy did not follow a push");
`endif

endmodule

// ===== hw/rtl/swbvh_back.sv =====
// Back end: per-lane bit-vote counters, hash, compare and result register.
module swbvh_back
  import swbvh_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  cmd_t         cmd_i,
  swbvh_out_if.source  out_o
);

  // Counters swing between minus and plus the window length.
  localparam int VW = $clog2(MAX_WINDOW + 1) + 1;

  logic signed [VW-1:0] votes_q [LANES][8];
  logic signed [VW-1:0] votes_d [LANES][8];
  logic                 out_valid_q;
  out_item_t            res_q, res_d;
  logic                 pop;
  lane_bytes_t          hash;
  lane_bytes_t          hash_out;
  logic                 match;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // Vote update: take back the leaving byte, add the entering one.
  always_comb begin
    logic signed [VW-1:0] base;
    logic signed [2:0]    d_add;
    logic signed [2:0]    d_sub;
    for (int l = 0; l < LANES; l++) begin
      for (int b = 0; b < 8; b++) begin
        base  = cmd_i.clear ? '0 : votes_q[l][b];
        d_add = cmd_i.missing ? 3'sd0 : (cmd_i.new_bytes[l][b] ? 3'sd1 : -3'sd1);
        d_sub = cmd_i.sub ? (cmd_i.old_bytes[l][b] ? -3'sd1 : 3'sd1) : 3'sd0;
        votes_d[l][b] = base + VW'(d_add) + VW'(d_sub);
        hash[l][b]    = !votes_d[l][b][VW-1] && (votes_d[l][b] != '0);
      end
    end
  end

  // Lane masking and pattern compare.
  always_comb begin
    match = cmd_i.full;
    for (int l = 0; l < LANES; l++) begin
      hash_out[l] = cfg_i.mask[l] ? hash[l] : 8'h00;
      if (cfg_i.mask[l] && (hash[l] != cfg_i.pattern[l])) begin
        match = 1'b0;
      end
    end
    res_d.hash_0      = hash_out[0];
    res_d.hash_1      = hash_out[1];
    res_d.hash_2      = hash_out[2];
    res_d.hash_3      = hash_out[3];
    res_d.window_full = cmd_i.full;
    res_d.match       = match;
  end

  // Counters and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        for (int b = 0; b < 8; b++) begin
          votes_q[l][b] <= '0;
        end
      end
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        votes_q     <= votes_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

`ifndef SYNTHESIS
  a_match_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!res_q.match || res_q.window_full))
    else $error("match reported on a window that is not full");
  a_missing_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cmd_i.missing) |=> (res_q.hash_0 == 8'h00 && res_q.hash_1 == 8'h00 &&
                                res_q.hash_2 == 8'h00 && res_q.hash_3 == 8'h00 &&
                                !res_q.window_full))
    else $error("missing item produced a nonempty result");
`endif

endmodule

// ===== hw/rtl/sliding_window_bit_vote_hash.sv =====
// Top level of the sliding-window bit-vote hash block.
//
// Takes one request per clock cycle sustained while results are taken and
// returns one result per request, in order; a result passes the staging
// register, the queue and the result register. That rate is set by the back
// end, where all lanes times eight vote counters move in parallel, and by
// the window store, which reads the leaving entry and writes the entering
// one in the same cycle on its single read and write port. A two-entry queue
// lets the front end and the back end stall apart. The window store needs no
// clearing pass: fill count and write slot track which entries are live.
// Writing the window length restarts the window.
module sliding_window_bit_vote_hash
  import swbvh_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swbvh_in_if.sink     in_i,
  swbvh_cfg_if.sink    cfg_i,
  swbvh_out_if.source  out_o
);

  cfg_t cfg;
  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // Request intake and classification.
  swbvh_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cfg_o       (cfg),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Decoupling queue.
  swbvh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_i       (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_o        (back_cmd)
  );

  // Vote counters and result.
  swbvh_back #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_o       (out_o)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the sliding-window bit-vote hash block.
module tb;
  import swbvh_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int PLAN_ROWS    = 31;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int BREAK_PCT    = 24;
  localparam int SHOW_LIMIT   = 10;

  // One row of the directed plan: a register write or a request.
  typedef struct {
    bit          is_write;
    cfg_reg_e    reg_sel;
    logic [31:0] wdata;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  swbvh_in_if  in_if ();
  swbvh_cfg_if cfg_if ();
  swbvh_out_if out_if ();

  sliding_window_bit_vote_hash #(
    .MAX_WINDOW(STORE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the window.
  logic [6:0]              win_len_q;
  lane_bytes_t             pattern_q;
  logic [LANES-1:0]        lane_en_q;
  logic signed [7:0]       vote_tally [LANES][8];
  lane_bytes_t             kept_bytes [STORE_DEPTH];
  int unsigned             held_items;
  int unsigned             next_slot;

  out_item_t               pending_hashes [$];
  int unsigned             mismatch_count = 0;
  int unsigned             cycle_count = 0;
  bit                      steady = 1'b0;

  // Window length as the block uses it: zero means one, the top is clipped.
  function automatic int unsigned span_of(input logic [6:0] len);
    if (len == 7'd0) return 1;
    if (len > STORE_DEPTH) return STORE_DEPTH;
    return len;
  endfunction

  function automatic void clear_votes();
    foreach (vote_tally[l, b]) vote_tally[l][b] = 8'sd0;
    held_items = 0;
    next_slot  = 0;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < BREAK_PCT);
  endfunction

  // Works out the result of one accepted request and advances the window.
  function automatic out_item_t predict_vote_hash(input in_item_t it);
    lane_bytes_t      entering;
    lane_bytes_t      hashes;
    int unsigned      span;
    int unsigned      old_slot;
    bit               full;
    bit               hit;
    out_item_t        res;
    span     = span_of(win_len_q);
    entering = {it.value_3, it.value_2, it.value_1, it.value_0};
    if (it.restart || it.item_missing) clear_votes();
    if (!it.item_missing) begin
      // The leaving byte takes its votes back before the new one votes.
      if (held_items >= span) begin
        old_slot = (next_slot + STORE_DEPTH - span) % STORE_DEPTH;
        for (int l = 0; l < LANES; l++)
          for (int b = 0; b < 8; b++)
            vote_tally[l][b] += kept_bytes[old_slot][l][b] ? -8'sd1 : 8'sd1;
      end
      for (int l = 0; l < LANES; l++)
        for (int b = 0; b < 8; b++)
          vote_tally[l][b] += entering[l][b] ? 8'sd1 : -8'sd1;
      kept_bytes[next_slot] = entering;
      next_slot = (next_slot + 1) % STORE_DEPTH;
      if (held_items < span) held_items++;
    end
    full = (held_items == span);
    hit  = full;
    for (int l = 0; l < LANES; l++) begin
      for (int b = 0; b < 8; b++) hashes[l][b] = (vote_tally[l][b] > 8'sd0);
      if (!lane_en_q[l]) hashes[l] = 8'h00;
      else if (hashes[l] != pattern_q[l]) hit = 1'b0;
    end
    res.hash_0      = hashes[0];
    res.hash_1      = hashes[1];
    res.hash_2      = hashes[2];
    res.hash_3      = hashes[3];
    res.window_full = full;
    res.match       = hit;
    return res;
  endfunction

  function automatic void record_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("hash result error (%s): expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void field_check(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) record_mismatch(what, want, got);
  endfunction

  // Writes one register and keeps the shadow copy in step.
  task automatic write_reg(input cfg_reg_e sel, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (sel)
      REG_WINDOW_LEN: begin
        win_len_q = value[6:0];
        clear_votes();
      end
      REG_PATTERN_HASH: pattern_q = value;
      REG_LANE_MASK:    lane_en_q = value[LANES-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offers one request after a random gap and records what it must return.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while (take_break()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = predict_vote_hash(it);
    pending_hashes = {pending_hashes, typed ? want : predicted};
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every result is back.
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk_i);
  endtask

  // Result side: random back-pressure, compare against the oldest expectation.
  initial begin : drive_ready
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_hashes.size() == 0) begin
        record_mismatch("result with no request pending", 32'h0, 32'(got));
      end else begin
        want = pending_hashes.pop_front();
        field_check("hash_0", want.hash_0, got.hash_0);
        field_check("hash_1", want.hash_1, got.hash_1);
        field_check("hash_2", want.hash_2, got.hash_2);
        field_check("hash_3", want.hash_3, got.hash_3);
        field_check("window_full", 8'(want.window_full), 8'(got.window_full));
        field_check("match", 8'(want.match), 8'(got.match));
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t        plan [PLAN_ROWS];
    bit               in_cfg;
    int unsigned      random_sent;
    int unsigned      phase;
    int unsigned      span;
    int unsigned      count;
    int unsigned      noise_pct;
    int unsigned      roll;
    logic [6:0]       len;
    logic [31:0]      base;
    logic [31:0]      word;
    logic [31:0]      wdata;
    in_item_t         it;

    // Directed plan: item fields are {value_0..value_3, item_missing, restart},
    // results are {hash_0..hash_3, window_full, match}.
    plan = '{
      // Reset settings: window of eight, pattern zero, all lanes on.
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
        1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
      // A missing item clears everything and reports zeros.
      '{0, REG_WINDOW_LEN, 32'h0, {8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h0F, 8'hF0, 8'h81, 8'h7E, 1'b0, 1'b1},
        0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1, 1'b1},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
      // Length zero behaves as a window of one.
      '{1, REG_WINDOW_LEN, 32'h0, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0},
        1, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0}},
      '{1, REG_PATTERN_HASH, 32'h00FF_00FF, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0},
        1, {8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1}},
      // With no lane enabled a full window always matches.
      '{1, REG_LANE_MASK, 32'h0, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{1, REG_LANE_MASK, 32'h5, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h3C, 8'hC3, 8'h96, 8'h69, 1'b0, 1'b0},
        1, {8'h3C, 8'h00, 8'h96, 8'h00, 1'b1, 1'b0}},
      // Lengths above the store depth are clipped to it.
      '{1, REG_WINDOW_LEN, 32'hFFFF_FF7F, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h01, 8'h02, 8'h04, 8'h08, 1'b0, 1'b0}, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h80, 8'h40, 8'h20, 8'h10, 1'b0, 1'b0}, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}, 0, '0},
      '{1, REG_WINDOW_LEN, 32'd64, '0, 0, '0},
      '{1, REG_LANE_MASK, 32'hFFFF_FFFF, '0, 0, '0},
      '{1, REG_PATTERN_HASH, 32'hFFFF_FFFF, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
        1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1},
        1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
      // Short window: fill, slide out, tie votes.
      '{1, REG_WINDOW_LEN, 32'd2, '0, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
        1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0},
        1, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b0, 1'b0}, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b0, 1'b0}, 0, '0},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b1, 1'b0},
        1, {8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
      '{0, REG_WINDOW_LEN, 32'h0, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0}, 0, '0}
    };

    // Every input known from time zero; reset held low first, then released.
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WINDOW_LEN;
    cfg_if.data  = '0;
    win_len_q    = WIN_LEN_RESET;
    pattern_q    = '0;
    lane_en_q    = LANE_MASK_RESET;
    clear_votes();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: writes wait until the block has returned everything.
    in_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!in_cfg) quiesce();
        in_cfg = 1'b1;
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        if (in_cfg) cfg_if.valid <= 1'b0;
        in_cfg = 1'b0;
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: noisy copies of one base word, pattern mostly that word.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiesce();
      case ($urandom_range(0, 9))
        0:       len = 7'd0;
        1:       len = 7'd1;
        2:       len = 7'd64;
        3:       len = 7'($urandom_range(65, 127));
        default: len = 7'($urandom_range(2, 12));
      endcase
      base  = $urandom;
      wdata = $urandom;
      wdata[6:0] = len;
      write_reg(REG_WINDOW_LEN, wdata);
      write_reg(REG_PATTERN_HASH, ($urandom_range(0, 4) != 0) ? base : $urandom);
      write_reg(REG_LANE_MASK, $urandom);
      cfg_if.valid <= 1'b0;

      steady    = (phase == 1);
      span      = span_of(len);
      count     = 2 * span + $urandom_range(8, 40) + (steady ? 60 : 0);
      noise_pct = (span > 16) ? 2 : 8;
      for (int n = 0; n < count; n++) begin
        word = base ^ ($urandom & $urandom & $urandom);
        it   = '0;
        roll = $urandom_range(0, 99);
        if (roll < noise_pct) begin
          case (roll % 3)
            0: begin
              it.item_missing = 1'b1;
              it.restart      = 1'($urandom_range(0, 1));
            end
            1:       it.restart = 1'b1;
            default: word = $urandom;
          endcase
        end
        {it.value_3, it.value_2, it.value_1, it.value_0} = word;
        send_item(it, 1'b0, '0);
      end
      random_sent += count;
      phase++;
    end
    steady = 1'b0;

    // Wrap-up: everything back, then a quiet spell to catch strays.
    in_if.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatch_count += pending_hashes.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
